// File: hdl/amgs_pkg.sv
`timescale 1ns / 1ps

package amgs_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int KEY_BITS     = 16;
	localparam int WEIGHT_BITS  = 16;

	localparam int VIDX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int EDGES   = MAX_VERTICES * MAX_VERTICES;
	localparam int EADDR_W = $clog2(EDGES);

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD_VERTEX    = 2'd0,
		OP_ADD_EDGE      = 2'd1,
		OP_GET_WEIGHT    = 2'd2,
		OP_GET_NEIGHBORS = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [KEY_BITS-1:0]    key_a;
		logic [KEY_BITS-1:0]    key_b;
		logic [WEIGHT_BITS-1:0] weight;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR_ROW,
		S_CLR_COL,
		S_SRC,
		S_DST,
		S_WREAD,
		S_NB_RD,
		S_NB_CHK,
		S_NB_KEY,
		S_NB_END,
		S_EMIT
	} state_t;

	function automatic logic [EADDR_W-1:0] edge_index(input logic [VIDX_W-1:0] row,
		input logic [VIDX_W-1:0] col);
		return EADDR_W'(row) * EADDR_W'(MAX_VERTICES) + EADDR_W'(col);
	endfunction

endpackage

// File: hdl/amgs_front.sv
`timescale 1ns / 1ps

module amgs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic [15:0]         vertex_key,
	input  logic [15:0]         other_key,
	input  logic signed [15:0]  weight_in,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output amgs_pkg::cmd_t      cmd
);

	logic           fr_v_q;
	amgs_pkg::cmd_t fr_cmd_q;
	amgs_pkg::cmd_t cls_cmd;

	// Keys are reduced to the table key width; the weight is sign extended
	// or truncated to the stored weight width.
	always_comb begin
		cls_cmd.key_a  = amgs_pkg::KEY_BITS'(vertex_key);
		cls_cmd.key_b  = amgs_pkg::KEY_BITS'(other_key);
		cls_cmd.weight = amgs_pkg::WEIGHT_BITS'(weight_in);
		cls_cmd.op     = amgs_pkg::op_t'(opcode);
	end

	assign in_ready  = !fr_v_q || cmd_ready;
	assign cmd_valid = fr_v_q;
	assign cmd       = fr_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_v_q <= 1'b0;
		end else if (in_ready) begin
			fr_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fr_cmd_q <= cls_cmd;
		end
	end

endmodule

// File: hdl/amgs_queue.sv
`timescale 1ns / 1ps

module amgs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  amgs_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output amgs_pkg::cmd_t pop_cmd
);

	amgs_pkg::cmd_t                entry_q [amgs_pkg::Q_DEPTH];
	logic [amgs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [amgs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [amgs_pkg::QCNT_W-1:0]   fill_q;
	logic                          push;
	logic                          pop;

	assign push_ready = fill_q != amgs_pkg::QCNT_W'(amgs_pkg::Q_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == amgs_pkg::QPTR_W'(amgs_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == amgs_pkg::QPTR_W'(amgs_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hdl/amgs_back.sv
`timescale 1ns / 1ps

module amgs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  amgs_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic signed [15:0]  weight_out,
	output logic [15:0]         neighbor_key,
	output logic                neighbor_valid,
	output logic                last
);

	localparam int VW = amgs_pkg::VIDX_W;
	localparam int CW = amgs_pkg::CNT_W;

	amgs_pkg::state_t state_q, state_d;
	amgs_pkg::cmd_t   cmd_q;

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    scan_idx_q;
	logic                             cmp_v_q;
	logic [VW-1:0]                    cmp_idx_q;
	logic [VW-1:0]                    r_q;
	logic [VW-1:0]                    clr_i_q;
	logic [CW-1:0]                    nb_i_q;
	logic                             pend_v_q;
	logic [amgs_pkg::KEY_BITS-1:0]    pend_key_q;
	logic [1:0]                       res_st_q;
	logic signed [15:0]               res_w_q;

	logic [amgs_pkg::KEY_BITS-1:0]    key_mem [amgs_pkg::MAX_VERTICES];
	logic [amgs_pkg::KEY_BITS-1:0]    key_rd_q;
	logic [amgs_pkg::WEIGHT_BITS-1:0] edge_mem [amgs_pkg::EDGES];
	logic [amgs_pkg::WEIGHT_BITS-1:0] edge_rd_q;

	logic                             out_valid_q;
	logic [1:0]                       status_q;
	logic signed [15:0]               weight_q;
	logic [15:0]                      nkey_q;
	logic                             nvalid_q;
	logic                             last_q;

	logic                             slot_free;
	logic [amgs_pkg::KEY_BITS-1:0]    tgt;
	logic                             hit;
	logic                             more;
	logic                             miss;
	logic                             full;
	logic [VW-1:0]                    cnt_idx;
	logic [VW-1:0]                    nb_idx;
	logic                             nb_more;
	logic                             edge_nz;
	logic                             pop;

	logic                             key_we;
	logic [VW-1:0]                    key_addr;
	logic                             edge_we;
	logic [amgs_pkg::EADDR_W-1:0]     edge_addr;
	logic [amgs_pkg::WEIGHT_BITS-1:0] edge_wdata;
	logic                             emit;
	logic [1:0]                       e_st;
	logic signed [15:0]               e_w;
	logic [amgs_pkg::KEY_BITS-1:0]    e_key;
	logic                             e_nv;
	logic                             e_last;

	assign slot_free = !out_valid_q || out_ready;
	assign tgt       = (state_q == amgs_pkg::S_SRC) ? cmd_q.key_a : cmd_q.key_b;
	assign hit       = cmp_v_q && (key_rd_q == tgt);
	assign more      = scan_idx_q < count_q;
	assign miss      = !cmp_v_q && !more;
	assign full      = count_q == CW'(amgs_pkg::MAX_VERTICES);
	assign cnt_idx   = count_q[VW-1:0];
	assign nb_idx    = nb_i_q[VW-1:0];
	assign nb_more   = nb_i_q < count_q;
	assign edge_nz   = edge_rd_q != '0;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amgs_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == amgs_pkg::OP_ADD_VERTEX) begin
						state_d = full ? amgs_pkg::S_EMIT : amgs_pkg::S_CLR_ROW;
					end else begin
						state_d = amgs_pkg::S_SRC;
					end
				end
			end
			amgs_pkg::S_CLR_ROW: state_d = amgs_pkg::S_CLR_COL;
			amgs_pkg::S_CLR_COL: begin
				state_d = (clr_i_q == cnt_idx) ? amgs_pkg::S_EMIT : amgs_pkg::S_CLR_ROW;
			end
			amgs_pkg::S_SRC: begin
				if (hit) begin
					state_d = (cmd_q.op == amgs_pkg::OP_GET_NEIGHBORS) ?
						amgs_pkg::S_NB_RD : amgs_pkg::S_DST;
				end else if (miss) begin
					state_d = amgs_pkg::S_EMIT;
				end
			end
			amgs_pkg::S_DST: begin
				if (hit) begin
					state_d = (cmd_q.op == amgs_pkg::OP_GET_WEIGHT) ?
						amgs_pkg::S_WREAD : amgs_pkg::S_EMIT;
				end else if (miss) begin
					state_d = amgs_pkg::S_EMIT;
				end
			end
			amgs_pkg::S_WREAD:  state_d = amgs_pkg::S_EMIT;
			amgs_pkg::S_NB_RD:  state_d = nb_more ? amgs_pkg::S_NB_CHK : amgs_pkg::S_NB_END;
			amgs_pkg::S_NB_CHK: state_d = edge_nz ? amgs_pkg::S_NB_KEY : amgs_pkg::S_NB_RD;
			amgs_pkg::S_NB_KEY: begin
				if (!pend_v_q || slot_free) begin
					state_d = amgs_pkg::S_NB_RD;
				end
			end
			amgs_pkg::S_NB_END, amgs_pkg::S_EMIT: begin
				if (slot_free) begin
					state_d = amgs_pkg::S_IDLE;
				end
			end
			default: state_d = amgs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready  = 1'b0;
		key_we     = 1'b0;
		key_addr   = scan_idx_q[VW-1:0];
		edge_we    = 1'b0;
		edge_addr  = amgs_pkg::edge_index(r_q, nb_idx);
		edge_wdata = '0;
		emit       = 1'b0;
		e_st       = amgs_pkg::STAT_OK;
		e_w        = '0;
		e_key      = '0;
		e_nv       = 1'b0;
		e_last     = 1'b1;
		unique case (state_q)
			amgs_pkg::S_IDLE: begin
				cmd_ready = 1'b1;
				key_addr  = cnt_idx;
				key_we    = cmd_valid && (cmd.op == amgs_pkg::OP_ADD_VERTEX) && !full;
			end
			amgs_pkg::S_CLR_ROW: begin
				edge_we   = 1'b1;
				edge_addr = amgs_pkg::edge_index(cnt_idx, clr_i_q);
			end
			amgs_pkg::S_CLR_COL: begin
				edge_we   = 1'b1;
				edge_addr = amgs_pkg::edge_index(clr_i_q, cnt_idx);
			end
			amgs_pkg::S_SRC: begin
				key_addr = scan_idx_q[VW-1:0];
			end
			amgs_pkg::S_DST: begin
				// The matrix read issued on a hit feeds the weight read state.
				key_addr   = scan_idx_q[VW-1:0];
				edge_addr  = amgs_pkg::edge_index(r_q, cmp_idx_q);
				edge_we    = hit && (cmd_q.op == amgs_pkg::OP_ADD_EDGE);
				edge_wdata = cmd_q.weight;
			end
			amgs_pkg::S_WREAD: begin
				edge_addr = amgs_pkg::edge_index(r_q, cmp_idx_q);
			end
			amgs_pkg::S_NB_RD: begin
				edge_addr = amgs_pkg::edge_index(r_q, nb_idx);
			end
			amgs_pkg::S_NB_CHK: begin
				key_addr = nb_idx;
			end
			amgs_pkg::S_NB_KEY: begin
				// A held neighbor goes out with last low once another is found.
				key_addr = nb_idx;
				emit     = pend_v_q && slot_free;
				e_key    = pend_key_q;
				e_nv     = 1'b1;
				e_last   = 1'b0;
			end
			amgs_pkg::S_NB_END: begin
				emit  = slot_free;
				e_key = pend_v_q ? pend_key_q : '0;
				e_nv  = pend_v_q;
			end
			amgs_pkg::S_EMIT: begin
				emit = slot_free;
				e_st = res_st_q;
				e_w  = res_w_q;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_addr] <= cmd.key_a;
		end
		key_rd_q <= key_mem[key_addr];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_addr] <= edge_wdata;
		end
		edge_rd_q <= edge_mem[edge_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amgs_pkg::S_IDLE;
			count_q     <= '0;
			cmp_v_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				amgs_pkg::S_IDLE: begin
					cmp_v_q <= 1'b0;
				end
				amgs_pkg::S_CLR_COL: begin
					if (clr_i_q == cnt_idx) begin
						count_q <= count_q + 1'b1;
					end
				end
				amgs_pkg::S_SRC, amgs_pkg::S_DST: begin
					if (hit) begin
						cmp_v_q  <= 1'b0;
						pend_v_q <= 1'b0;
					end else begin
						cmp_v_q <= more;
					end
				end
				amgs_pkg::S_NB_KEY: begin
					if (!pend_v_q || slot_free) begin
						pend_v_q <= 1'b1;
					end
				end
				default: begin
					cmp_v_q <= cmp_v_q;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			amgs_pkg::S_IDLE: begin
				if (pop) begin
					cmd_q      <= cmd;
					scan_idx_q <= '0;
					clr_i_q    <= '0;
					// Only add vertex can report a full table.
					res_st_q   <= (full && (cmd.op == amgs_pkg::OP_ADD_VERTEX)) ?
						amgs_pkg::STAT_FULL : amgs_pkg::STAT_OK;
					res_w_q    <= '0;
				end
			end
			amgs_pkg::S_CLR_COL: begin
				clr_i_q <= clr_i_q + 1'b1;
			end
			amgs_pkg::S_SRC, amgs_pkg::S_DST: begin
				if (hit) begin
					r_q        <= (state_q == amgs_pkg::S_SRC) ? cmp_idx_q : r_q;
					scan_idx_q <= '0;
					nb_i_q     <= '0;
				end else if (more) begin
					cmp_idx_q  <= scan_idx_q[VW-1:0];
					scan_idx_q <= scan_idx_q + 1'b1;
				end else if (miss) begin
					res_st_q <= amgs_pkg::STAT_NOT_FOUND;
				end
			end
			amgs_pkg::S_WREAD: begin
				res_w_q <= 16'($signed(edge_rd_q));
			end
			amgs_pkg::S_NB_CHK: begin
				if (!edge_nz) begin
					nb_i_q <= nb_i_q + 1'b1;
				end
			end
			amgs_pkg::S_NB_KEY: begin
				if (!pend_v_q || slot_free) begin
					pend_key_q <= key_rd_q;
					nb_i_q     <= nb_i_q + 1'b1;
				end
			end
			default: begin
				res_st_q <= res_st_q;
			end
		endcase
		if (emit) begin
			status_q <= e_st;
			weight_q <= e_w;
			nkey_q   <= 16'(e_key);
			nvalid_q <= e_nv;
			last_q   <= e_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign weight_out     = weight_q;
	assign neighbor_key   = nkey_q;
	assign neighbor_valid = nvalid_q;
	assign last           = last_q;

endmodule

// File: hdl/adjacency_matrix_graph_store_core.sv
// Path from input accept to result: front register, queue, then the back end. Add vertex
// writes the key and clears the new row and column (nothing when the table is full); the
// others search the key table for their keys, then add edge writes and get weight reads the
// matrix. Get neighbors reads the row, fetching each neighbor's key; each neighbor goes out
// once the next is found. One item at a time; the next is taken after the result is placed.
// Reset (arst_n low): queue empty, no vertices; key table and weight matrix not cleared.
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic [15:0]         vertex_key,
	input  logic [15:0]         other_key,
	input  logic signed [15:0]  weight_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic signed [15:0]  weight_out,
	output logic [15:0]         neighbor_key,
	output logic                neighbor_valid,
	output logic                last
);

	logic           fq_valid;
	logic           fq_ready;
	amgs_pkg::cmd_t fq_cmd;
	logic           qb_valid;
	logic           qb_ready;
	amgs_pkg::cmd_t qb_cmd;

	amgs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.vertex_key (vertex_key),
		.other_key  (other_key),
		.weight_in  (weight_in),
		.cmd_valid  (fq_valid),
		.cmd_ready  (fq_ready),
		.cmd        (fq_cmd)
	);

	amgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	amgs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (qb_valid),
		.cmd_ready      (qb_ready),
		.cmd            (qb_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.weight_out     (weight_out),
		.neighbor_key   (neighbor_key),
		.neighbor_valid (neighbor_valid),
		.last           (last)
	);

`ifndef NO_ASSERTIONS
	a_full_single : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == amgs_pkg::STAT_FULL) |-> last && !neighbor_valid
			&& (weight_out == 16'sd0))
		else $error("table full result is not a single plain item");

	a_neighbor_ok : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && neighbor_valid |-> (status == amgs_pkg::STAT_OK) && (weight_out == 16'sd0))
		else $error("neighbor item carries a bad status or weight");

	a_plain_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !neighbor_valid |-> last && (neighbor_key == 16'd0))
		else $error("item without a neighbor is not the last one or has a key");
`endif

endmodule
